>>> rtl/dtu_pkg.sv
// Shared types, codes and helpers for the data-transfer unit.
// No dependencies; imported by dtu_regs, the core and the bench.
package dtu_pkg;

	localparam int NUM_REGS = 7;

	// instruction codes
	localparam logic [3:0] OP_MOV  = 4'd0;
	localparam logic [3:0] OP_MVI  = 4'd1;
	localparam logic [3:0] OP_LXI  = 4'd2;
	localparam logic [3:0] OP_LDA  = 4'd3;
	localparam logic [3:0] OP_STA  = 4'd4;
	localparam logic [3:0] OP_LHLD = 4'd5;
	localparam logic [3:0] OP_SHLD = 4'd6;
	localparam logic [3:0] OP_STAX = 4'd7;
	localparam logic [3:0] OP_XCHG = 4'd8;

	// register / pair codes
	localparam logic [2:0] R_A = 3'd0;
	localparam logic [2:0] R_B = 3'd1;
	localparam logic [2:0] R_C = 3'd2;
	localparam logic [2:0] R_D = 3'd3;
	localparam logic [2:0] R_E = 3'd4;
	localparam logic [2:0] R_H = 3'd5;
	localparam logic [2:0] R_L = 3'd6;
	localparam logic [2:0] R_M = 3'd7;

	// error codes
	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_PAIR = 2'd2;

	typedef logic [NUM_REGS-1:0][7:0] regs_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [2:0]  dst_code;
		logic [2:0]  src_code;
		logic [7:0]  imm_byte;
		logic [15:0] addr_word;
	} req_t;

	typedef struct packed {
		logic [1:0]  error_code;
		logic [7:0]  acc_out;
		logic [7:0]  b_out;
		logic [7:0]  c_out;
		logic [7:0]  d_out;
		logic [7:0]  e_out;
		logic [7:0]  h_out;
		logic [7:0]  l_out;
		logic [1:0]  mem_wrote;
		logic [15:0] mem_addr_out;
		logic [7:0]  mem_data_out;
	} rsp_t;

	// write-back stage status handed to the register file
	typedef struct packed {
		logic       valid;
		logic       commit;
		req_t       req;
		logic [1:0] err;
		logic [7:0] d1;
	} wb_t;

	function automatic logic [7:0] reg_sel(input regs_t r, input logic [2:0] code);
		logic [7:0] v;
		v = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (code == 3'(i)) begin
				v = r[i];
			end
		end
		return v;
	endfunction

endpackage

>>> rtl/dtu_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module dtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> rtl/dtu_regs.sv
// Register file A..L with write-back logic and a forwarding output.
// Depends on dtu_pkg.
module dtu_regs import dtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wb_t        wb,
	input  logic [7:0] d2,
	output regs_t      regs_nxt,
	output regs_t      regs_fwd
);

	regs_t regs_q;

	always_comb begin
		regs_nxt = regs_q;
		if (wb.err == ERR_OK) begin
			unique case (wb.req.req_type)
				OP_MOV: begin
					if (wb.req.dst_code != R_M) begin
						for (int i = 0; i < NUM_REGS; i++) begin
							if (wb.req.dst_code == 3'(i)) begin
								regs_nxt[i] = (wb.req.src_code == R_M) ? wb.d1
									: reg_sel(regs_q, wb.req.src_code);
							end
						end
					end
				end
				OP_MVI: begin
					for (int i = 0; i < NUM_REGS; i++) begin
						if (wb.req.dst_code == 3'(i)) begin
							regs_nxt[i] = wb.req.imm_byte;
						end
					end
				end
				OP_LXI: begin
					// error check upstream guarantees B, D, H or M here
					if (wb.req.dst_code == R_B) begin
						regs_nxt[R_B] = wb.req.addr_word[15:8];
						regs_nxt[R_C] = wb.req.addr_word[7:0];
					end else if (wb.req.dst_code == R_D) begin
						regs_nxt[R_D] = wb.req.addr_word[15:8];
						regs_nxt[R_E] = wb.req.addr_word[7:0];
					end else begin
						regs_nxt[R_H] = wb.req.addr_word[15:8];
						regs_nxt[R_L] = wb.req.addr_word[7:0];
					end
				end
				OP_LDA: regs_nxt[R_A] = wb.d1;
				OP_LHLD: begin
					regs_nxt[R_L] = wb.d1;
					regs_nxt[R_H] = d2;
				end
				OP_XCHG: begin
					regs_nxt[R_D] = regs_q[R_H];
					regs_nxt[R_H] = regs_q[R_D];
					regs_nxt[R_E] = regs_q[R_L];
					regs_nxt[R_L] = regs_q[R_E];
				end
				default: ;
			endcase
		end
	end

	// next instruction sees the values being written back this cycle
	assign regs_fwd = wb.valid ? regs_nxt : regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wb.valid && wb.commit) begin
			regs_q <= regs_nxt;
		end
	end

endmodule

>>> rtl/cpu_data_transfer_unit_core.sv
// Data-transfer instruction unit: one instruction per item on a byte register file and memory.
// Stages: input stage A, stage B, write-back stage W, then the registered response.
// Stage A issues only while stage B is empty and no finished result is stalled,
// as B holds the single memory port (LHLD/SHLD use it twice). Reset: registers clear
// at once; the memory is then swept to zero, during which req_stall stays high.
// Depends on dtu_pkg, dtu_ram, dtu_regs.
module cpu_data_transfer_unit_core import dtu_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int DEPTH = 1 << ADDR_BITS;
	typedef logic [ADDR_BITS-1:0] maddr_t;

	// memory clear sweep
	logic   clr_busy_q;
	maddr_t clr_addr_q;

	// input stage (A): item waiting to issue its first memory access
	logic a_valid_q;
	req_t a_req_q;

	// stage B: second memory access (LHLD / SHLD), first read data returns
	logic       b_valid_s2;
	req_t       b_req_s2;
	logic [1:0] b_err_s2;
	logic [1:0] b_wrote_s2;
	maddr_t     b_addr_s2;
	logic [7:0] b_wdata_s2;
	logic [7:0] b_hdata_s2;

	// stage W: second read data returns, registers written back
	logic       w_valid_s3;
	req_t       w_req_s3;
	logic [1:0] w_err_s3;
	logic [1:0] w_wrote_s3;
	maddr_t     w_addr_s3;
	logic [7:0] w_wdata_s3;
	logic [7:0] w_d1_s3;

	logic adv, a_fire, b_go;

	// stage A decode
	regs_t      regs_fwd, regs_nxt;
	logic [1:0] a_err, a_wrote;
	logic       a_rd, a_wr;
	maddr_t     a_addr, hl_addr;
	logic [7:0] a_wdata;

	// memory port
	logic       ram_en, ram_we;
	maddr_t     ram_addr;
	logic [7:0] ram_wdata, ram_rdata;

	wb_t wb;

	// whole pipe holds while a finished result is stalled
	assign adv       = !rsp_valid || !rsp_stall;
	// A needs the port, which B holds in its cycle
	assign a_fire    = a_valid_q && !b_valid_s2 && adv && !clr_busy_q;
	assign b_go      = b_valid_s2 && adv;
	assign req_stall = clr_busy_q || (a_valid_q && !a_fire);

	assign hl_addr = maddr_t'({regs_fwd[R_H], regs_fwd[R_L]});

	always_comb begin
		a_err   = ERR_OK;
		a_rd    = 1'b0;
		a_wr    = 1'b0;
		a_wrote = 2'd0;
		a_addr  = maddr_t'(a_req_q.addr_word);
		a_wdata = '0;
		unique case (a_req_q.req_type)
			OP_MOV: begin
				if (a_req_q.dst_code == R_M && a_req_q.src_code == R_M) begin
					a_err = ERR_PAIR;
				end else if (a_req_q.dst_code == R_M) begin
					a_wr    = 1'b1;
					a_wrote = 2'd1;
					a_addr  = hl_addr;
					a_wdata = reg_sel(regs_fwd, a_req_q.src_code);
				end else if (a_req_q.src_code == R_M) begin
					a_rd   = 1'b1;
					a_addr = hl_addr;
				end
			end
			OP_MVI: begin
				if (a_req_q.dst_code == R_M) begin
					a_wr    = 1'b1;
					a_wrote = 2'd1;
					a_addr  = hl_addr;
					a_wdata = a_req_q.imm_byte;
				end
			end
			OP_LXI: begin
				if (!(a_req_q.dst_code == R_B || a_req_q.dst_code == R_D ||
				      a_req_q.dst_code == R_H || a_req_q.dst_code == R_M)) begin
					a_err = ERR_PAIR;
				end
			end
			OP_LDA: a_rd = 1'b1;
			OP_STA: begin
				a_wr    = 1'b1;
				a_wrote = 2'd1;
				a_wdata = regs_fwd[R_A];
			end
			OP_LHLD: a_rd = 1'b1;
			OP_SHLD: begin
				a_wr    = 1'b1;
				a_wrote = 2'd2;
				a_wdata = regs_fwd[R_L];
			end
			OP_STAX: begin
				if (a_req_q.dst_code == R_B) begin
					a_wr    = 1'b1;
					a_wrote = 2'd1;
					a_addr  = maddr_t'({regs_fwd[R_B], regs_fwd[R_C]});
					a_wdata = regs_fwd[R_A];
				end else if (a_req_q.dst_code == R_D) begin
					a_wr    = 1'b1;
					a_wrote = 2'd1;
					a_addr  = maddr_t'({regs_fwd[R_D], regs_fwd[R_E]});
					a_wdata = regs_fwd[R_A];
				end else begin
					a_err = ERR_PAIR;
				end
			end
			default: ;
		endcase
	end

	// port arbitration: clear sweep, then stage B, then stage A (never both B and A)
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = a_addr;
		ram_wdata = a_wdata;
		priority if (clr_busy_q) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = '0;
		end else if (b_go) begin
			ram_en    = b_req_s2.req_type == OP_LHLD || b_req_s2.req_type == OP_SHLD;
			ram_we    = b_req_s2.req_type == OP_SHLD;
			ram_addr  = maddr_t'(b_addr_s2 + 1'b1);  // wraps within the address space
			ram_wdata = b_hdata_s2;
		end else if (a_fire) begin
			ram_en = a_rd || a_wr;
			ram_we = a_wr;
		end
	end

	dtu_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign wb.valid  = w_valid_s3;
	assign wb.commit = adv;
	assign wb.req    = w_req_s3;
	assign wb.err    = w_err_s3;
	assign wb.d1     = w_d1_s3;

	dtu_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wb       (wb),
		.d2       (ram_rdata),
		.regs_nxt (regs_nxt),
		.regs_fwd (regs_fwd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			a_valid_q  <= 1'b0;
			b_valid_s2 <= 1'b0;
			w_valid_s3 <= 1'b0;
			rsp_valid  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= maddr_t'(clr_addr_q + 1'b1);
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (req_valid && !req_stall) begin
				a_valid_q <= 1'b1;
			end else if (a_fire) begin
				a_valid_q <= 1'b0;
			end
			if (adv) begin
				b_valid_s2 <= a_fire;
				w_valid_s3 <= b_valid_s2;
				rsp_valid  <= w_valid_s3;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			a_req_q <= req;
		end
		if (a_fire) begin
			b_req_s2   <= a_req_q;
			b_err_s2   <= a_err;
			b_wrote_s2 <= a_wrote;
			b_addr_s2  <= a_addr;
			b_wdata_s2 <= a_wdata;
			b_hdata_s2 <= regs_fwd[R_H];
		end
		if (b_go) begin
			w_req_s3   <= b_req_s2;
			w_err_s3   <= b_err_s2;
			w_wrote_s3 <= b_wrote_s2;
			w_addr_s3  <= b_addr_s2;
			w_wdata_s3 <= b_wdata_s2;
			w_d1_s3    <= ram_rdata;  // read issued by stage A
		end
		if (adv && w_valid_s3) begin
			rsp.error_code   <= w_err_s3;
			rsp.acc_out      <= regs_nxt[R_A];
			rsp.b_out        <= regs_nxt[R_B];
			rsp.c_out        <= regs_nxt[R_C];
			rsp.d_out        <= regs_nxt[R_D];
			rsp.e_out        <= regs_nxt[R_E];
			rsp.h_out        <= regs_nxt[R_H];
			rsp.l_out        <= regs_nxt[R_L];
			rsp.mem_wrote    <= w_wrote_s3;
			rsp.mem_addr_out <= (w_wrote_s3 != 2'd0) ? 16'(w_addr_s3) : 16'd0;
			rsp.mem_data_out <= (w_wrote_s3 != 2'd0) ? w_wdata_s3 : 8'd0;
		end
	end

endmodule

>>> bench/tb_cpu_data_transfer_unit_core.sv
// Self-checking bench for cpu_data_transfer_unit_core: directed table, then biased random instructions.
// A behavioural predictor of the register file and byte memory supplies the expected responses the table does not give.
// Depends on dtu_pkg and the RTL of the block; nothing else.
module tb_cpu_data_transfer_unit_core;
	import dtu_pkg::*;

	localparam int ADDR_BITS = 16;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam int RAND_ITEMS = 1100;

	// opcodes outside the instruction group: accepted, change nothing
	localparam logic [3:0] OP_UNDEF_LO = 4'd9;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	// pressure points within the random part
	localparam int HOLD_OFF_AT = 200;
	localparam int HOLD_OFF_CYC = 400;
	localparam int DRAIN_AT = 600;
	localparam int BURST_LO = 300;
	localparam int BURST_HI = 450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// predictor state
	logic [7:0] cpu_regs [NUM_REGS];
	logic [7:0] ram_img [MEM_WORDS];

	rsp_t rsp_due [$];
	int fail_cnt = 0;
	bit hold_off_req = 1'b0;

	typedef struct {
		req_t instr;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_tab [25];

	cpu_data_transfer_unit_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// note one byte written by the instruction, and update the memory image
	function automatic void store_byte(inout rsp_t o, input logic [ADDR_BITS-1:0] a,
			input logic [7:0] d);
		ram_img[a] = d;
		o.mem_wrote = 2'd1;
		o.mem_addr_out = 16'(a);
		o.mem_data_out = d;
	endfunction

	// execute one instruction on the predictor state, return the response it should give
	function automatic rsp_t exec_instr(input req_t r);
		rsp_t o;
		logic [ADDR_BITS-1:0] hl;
		logic [ADDR_BITS-1:0] da;
		logic [ADDR_BITS-1:0] da_nx;
		logic [2:0] hi;
		logic [7:0] t;
		o = '0;
		hl = ADDR_BITS'({cpu_regs[R_H], cpu_regs[R_L]});
		da = ADDR_BITS'(r.addr_word);
		da_nx = da + 1'b1;
		case (r.req_type)
			OP_MOV: begin
				if (r.dst_code == R_M && r.src_code == R_M) begin
					o.error_code = ERR_PAIR;
				end else if (r.dst_code == R_M) begin
					store_byte(o, hl, cpu_regs[r.src_code]);
				end else if (r.src_code == R_M) begin
					cpu_regs[r.dst_code] = ram_img[hl];
				end else begin
					cpu_regs[r.dst_code] = cpu_regs[r.src_code];
				end
			end
			OP_MVI: begin
				if (r.dst_code == R_M) begin
					store_byte(o, hl, r.imm_byte);
				end else begin
					cpu_regs[r.dst_code] = r.imm_byte;
				end
			end
			OP_LXI: begin
				if (r.dst_code == R_B || r.dst_code == R_D || r.dst_code == R_H ||
						r.dst_code == R_M) begin
					hi = (r.dst_code == R_M) ? R_H : r.dst_code;
					cpu_regs[hi] = r.addr_word[15:8];
					cpu_regs[hi + 3'd1] = r.addr_word[7:0];
				end else begin
					o.error_code = ERR_PAIR;
				end
			end
			OP_LDA: begin
				cpu_regs[R_A] = ram_img[da];
			end
			OP_STA: begin
				store_byte(o, da, cpu_regs[R_A]);
			end
			OP_LHLD: begin
				cpu_regs[R_L] = ram_img[da];
				cpu_regs[R_H] = ram_img[da_nx];
			end
			OP_SHLD: begin
				store_byte(o, da, cpu_regs[R_L]);
				ram_img[da_nx] = cpu_regs[R_H];
				o.mem_wrote = 2'd2;
			end
			OP_STAX: begin
				if (r.dst_code == R_B || r.dst_code == R_D) begin
					store_byte(o, ADDR_BITS'({cpu_regs[r.dst_code],
						cpu_regs[r.dst_code + 3'd1]}), cpu_regs[R_A]);
				end else begin
					o.error_code = ERR_PAIR;
				end
			end
			OP_XCHG: begin
				t = cpu_regs[R_D];
				cpu_regs[R_D] = cpu_regs[R_H];
				cpu_regs[R_H] = t;
				t = cpu_regs[R_E];
				cpu_regs[R_E] = cpu_regs[R_L];
				cpu_regs[R_L] = t;
			end
			default: begin
			end
		endcase
		o.acc_out = cpu_regs[R_A];
		o.b_out = cpu_regs[R_B];
		o.c_out = cpu_regs[R_C];
		o.d_out = cpu_regs[R_D];
		o.e_out = cpu_regs[R_E];
		o.h_out = cpu_regs[R_H];
		o.l_out = cpu_regs[R_L];
		return o;
	endfunction

	// addresses kept mostly in three small windows (one at the top, for the wrap),
	// so loads and M operands hit bytes stored earlier
	function automatic logic [15:0] hot_addr();
		logic [3:0] low;
		low = 4'($urandom);
		case ($urandom_range(0, 2))
			0: return {12'h000, low};
			1: return {12'hFFF, low};
			default: return {12'h123, low};
		endcase
	endfunction

	function automatic req_t rand_instr();
		req_t r;
		r.dst_code = 3'($urandom);
		r.src_code = 3'($urandom);
		r.imm_byte = 8'($urandom);
		r.addr_word = 16'($urandom);
		if ($urandom_range(0, 99) < 6) begin
			r.req_type = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		end else begin
			r.req_type = 4'($urandom_range(OP_MOV, OP_XCHG));
		end
		if ($urandom_range(0, 3) != 0) begin
			r.addr_word = hot_addr();
		end
		return r;
	endfunction

	// sender gap: mostly none, some short, a few long; none inside the burst window
	function automatic int idle_len(input int idx);
		int pick;
		if (idx >= BURST_LO && idx < BURST_HI) begin
			return 0;
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return 0;
		end else if (pick < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// present one item, hold it until taken, then log the expected response.
	// valid stays high across back-to-back items (no drop and re-raise in one step)
	task automatic offer(input req_t instr, input bit typed, input rsp_t want, input int gap);
		rsp_t pred;
		req <= instr;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall !== 1'b0);
		pred = exec_instr(instr);
		rsp_due.push_back(typed ? want : pred);
		if (gap > 0) begin
			req_valid <= 1'b0;
			req <= req_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// response checker: edge-sampled, so it sees the same handshake the block sees
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (rsp_due.size() == 0) begin
				$error("response with none outstanding");
				fail_cnt++;
			end else begin
				want = rsp_due.pop_front();
				cmp_field("error_code", 16'(want.error_code), 16'(rsp.error_code));
				cmp_field("acc_out", 16'(want.acc_out), 16'(rsp.acc_out));
				cmp_field("b_out", 16'(want.b_out), 16'(rsp.b_out));
				cmp_field("c_out", 16'(want.c_out), 16'(rsp.c_out));
				cmp_field("d_out", 16'(want.d_out), 16'(rsp.d_out));
				cmp_field("e_out", 16'(want.e_out), 16'(rsp.e_out));
				cmp_field("h_out", 16'(want.h_out), 16'(rsp.h_out));
				cmp_field("l_out", 16'(want.l_out), 16'(rsp.l_out));
				cmp_field("mem_wrote", 16'(want.mem_wrote), 16'(rsp.mem_wrote));
				cmp_field("mem_addr_out", want.mem_addr_out, rsp.mem_addr_out);
				cmp_field("mem_data_out", 16'(want.mem_data_out), 16'(rsp.mem_data_out));
			end
		end
	end

	// receiver back-pressure: runs of free cycles and stalls, now and then a long
	// free stretch; a hold-off request forces one long stall so the pipe backs up
	initial begin : rsp_side
		int stall_run;
		int free_run;
		stall_run = 0;
		free_run = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_run = HOLD_OFF_CYC;
				free_run = 0;
			end
			if (stall_run > 0) begin
				rsp_stall <= 1'b1;
				stall_run--;
			end else if (free_run > 0) begin
				rsp_stall <= 1'b0;
				free_run--;
			end else begin
				rsp_stall <= 1'b0;
				free_run = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 6);
				stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) :
					$urandom_range(1, 3);
			end
		end
	end

	initial begin : stim
		// directed part; typed responses are those readable from a cleared machine
		dir_tab = '{
			// load from cleared memory
			'{req_t'{OP_LDA, R_A, R_A, 8'h00, 16'h0000}, 1'b1,
				rsp_t'{ERR_OK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd0, 16'h0000, 8'h00}},
			// MOV M,M is an illegal combination
			'{req_t'{OP_MOV, R_M, R_M, 8'hFF, 16'hFFFF}, 1'b1,
				rsp_t'{ERR_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd0, 16'h0000, 8'h00}},
			// LXI on a non-pair register
			'{req_t'{OP_LXI, R_A, R_A, 8'h00, 16'hFFFF}, 1'b1,
				rsp_t'{ERR_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd0, 16'h0000, 8'h00}},
			// STAX only takes B or D
			'{req_t'{OP_STAX, R_H, R_A, 8'h00, 16'h0000}, 1'b1,
				rsp_t'{ERR_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd0, 16'h0000, 8'h00}},
			'{req_t'{OP_MVI, R_A, R_A, 8'hFF, 16'h0000}, 1'b1,
				rsp_t'{ERR_OK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd0, 16'h0000, 8'h00}},
			'{req_t'{OP_STA, R_A, R_A, 8'h00, 16'hFFFF}, 1'b1,
				rsp_t'{ERR_OK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				2'd1, 16'hFFFF, 8'hFF}},
			'{req_t'{OP_LXI, R_H, R_A, 8'h00, 16'hFFFF}, 1'b1,
				rsp_t'{ERR_OK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
				2'd0, 16'h0000, 8'h00}},
			// two-byte store and load across the top of memory
			'{req_t'{OP_SHLD, R_A, R_A, 8'h00, 16'hFFFF}, 1'b0, '0},
			'{req_t'{OP_LHLD, R_A, R_A, 8'h00, 16'hFFFF}, 1'b0, '0},
			'{req_t'{OP_LXI, R_M, R_A, 8'h00, 16'h0100}, 1'b0, '0},
			'{req_t'{OP_MOV, R_M, R_A, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_MOV, R_B, R_M, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_MVI, R_M, R_A, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_MOV, R_C, R_M, 8'h00, 16'h0000}, 1'b0, '0},
			// some unused operands carry all ones and must be ignored
			'{req_t'{OP_LXI, R_B, R_M, 8'hFF, 16'h0100}, 1'b0, '0},
			'{req_t'{OP_LXI, R_D, R_A, 8'h00, 16'hFFFE}, 1'b0, '0},
			'{req_t'{OP_STAX, R_B, R_A, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_STAX, R_D, R_M, 8'hFF, 16'hFFFF}, 1'b0, '0},
			'{req_t'{OP_MVI, R_L, R_A, 8'h5A, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_XCHG, R_M, R_M, 8'hFF, 16'hFFFF}, 1'b0, '0},
			'{req_t'{OP_MOV, R_E, R_L, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_MOV, R_A, R_A, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_LDA, R_A, R_A, 8'h00, 16'hFFFF}, 1'b0, '0},
			// undefined opcodes: no effect
			'{req_t'{OP_UNDEF_LO, R_A, R_A, 8'h00, 16'h0000}, 1'b0, '0},
			'{req_t'{OP_UNDEF_HI, R_M, R_M, 8'hFF, 16'hFFFF}, 1'b0, '0}
		};

		foreach (cpu_regs[i]) cpu_regs[i] = '0;
		foreach (ram_img[i]) ram_img[i] = '0;

		// reset once; the block then sweeps its memory with req_stall high
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			offer(dir_tab[i].instr, dir_tab[i].typed, dir_tab[i].want, idle_len(-1));
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// long receiver hold-off while items keep coming
			if (i == HOLD_OFF_AT) begin
				hold_off_req = 1'b1;
			end
			offer(rand_instr(), 1'b0, '0, (i == DRAIN_AT) ? 0 : idle_len(i));
			// sender pause until the block has drained completely
			if (i == DRAIN_AT) begin
				req_valid <= 1'b0;
				wait (rsp_due.size() == 0);
				@(posedge clk);
			end
		end
		req_valid <= 1'b0;

		wait (rsp_due.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog: the memory sweep plus the slowest legal run, several times over
	initial begin : watchdog
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/dtu_pkg.sv
rtl/dtu_ram.sv
rtl/dtu_regs.sv
rtl/cpu_data_transfer_unit_core.sv
bench/tb_cpu_data_transfer_unit_core.sv
